### src/deq_pkg.sv
// Shared types, constants and ring-pointer helpers for the double-ended queue.
package deq_pkg;

  // Storage geometry
  localparam int DEPTH       = 16;
  localparam int VALUE_BITS  = 32;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Fixed field widths of the transfer payloads
  localparam int ITEM_W      = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int STORE_W     = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DRAIN      = 3'd4,
    CMD_WALK_FWD   = 3'd5,
    CMD_WALK_BWD   = 3'd6,
    CMD_QUERY      = 3'd7
  } deq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef struct packed {
    deq_cmd_t            cmd;
    logic [ITEM_W-1:0]   item_value;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0]      out_value;
    deq_status_t            status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic                   last_of_run;
  } out_item_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EMIT = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic start;   // accepted command begins a run of storage reads
    logic emit;    // load the next read entry into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken
    logic empty;     // no entries held
    logic last;      // the entry now being read ends the run
  } dp_stat_t;

  // Commands that read entries from storage
  function automatic logic is_run_cmd(deq_cmd_t c);
    logic r;
    case (c)
      CMD_POP_FRONT, CMD_POP_BACK, CMD_DRAIN, CMD_WALK_FWD, CMD_WALK_BWD: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Ring position p advanced by off, where off is at most DEPTH
  function automatic logic [PTR_W-1:0] ring_fwd(logic [PTR_W-1:0] p,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - PTR_W){1'b0}}, p} + {1'b0, off};
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // Ring position one step back
  function automatic logic [PTR_W-1:0] ring_back(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

### src/double_ended_queue.sv
// Top level of the bounded double-ended queue of handle words.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data  (in_item_t)
//   out      output     out_valid / out_ready out_data (out_item_t)
//
// Push, query, and any command on an empty queue give their single result in the
// cycle after the input transfer. A pop (one entry), walk or drain (every held
// entry) reads storage through the single registered read port and moves one
// entry per cycle to the output register while the output is not stalled.
// Reset empties the queue; stored entries are not cleared. A stall on the output
// holds the run in place, and a new input is taken only once the run has ended.
module double_ended_queue import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // Sequencing of commands and runs
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (in_data.cmd),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Storage, pointers and result register
  deq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### src/deq_ctrl.sv
// Controller state machine: sequences command acceptance and multi-entry runs.
module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  deq_cmd_t cmd,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  ctl
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    case (state)
      CS_IDLE: begin
        in_ready   = stat.out_free;
        ctl.accept = in_valid && stat.out_free;
        ctl.start  = ctl.accept && is_run_cmd(cmd) && !stat.empty;
        if (ctl.start) begin
          state_next = CS_EMIT;
        end
      end
      CS_EMIT: begin
        ctl.emit = stat.out_free;
        if (stat.out_free && stat.last) begin
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

### src/deq_datapath.sv
// Datapath: entry storage, ring pointers, run counters and the output register.
module deq_datapath import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  dp_cmd_t   ctl,
  output dp_stat_t  stat,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [STORE_W-1:0] mem [DEPTH];
  logic [STORE_W-1:0] rdata;

  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] left, left_next;
  deq_cmd_t         run_cmd, run_cmd_next;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic             load;
  out_item_t        res;
  logic [CNT_W-1:0] res_count;

  assign stat.out_free = !out_valid || out_ready;
  assign stat.empty    = (count == '0);
  assign stat.last     = (left == CNT_W'(1));

  // Command decode and next-state computation
  always_comb begin
    head_next    = head;
    count_next   = count;
    rd_ptr_next  = rd_ptr;
    left_next    = left;
    run_cmd_next = run_cmd;
    wr_en        = 1'b0;
    wr_addr      = head;
    load         = 1'b0;
    res          = '0;
    res_count    = count;

    if (ctl.accept) begin
      load = !ctl.start;
      res.last_of_run = 1'b1;
      case (in_data.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (count == CNT_W'(DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            wr_en = 1'b1;
            if (in_data.cmd == CMD_PUSH_FRONT) begin
              wr_addr   = ring_back(head);
              head_next = wr_addr;
            end else begin
              wr_addr = ring_fwd(head, count);
            end
            count_next = count + CNT_W'(1);
            res_count  = count_next;
            res.status = ST_OK;
          end
        end
        CMD_QUERY: begin
          res.status = ST_OK;
        end
        default: begin
          if (count == '0) begin
            res.status = ST_EMPTY;
          end else begin
            // Set up a run: first read address and number of entries
            run_cmd_next = in_data.cmd;
            if (in_data.cmd == CMD_POP_FRONT || in_data.cmd == CMD_POP_BACK) begin
              left_next = CNT_W'(1);
            end else begin
              left_next = count;
            end
            if (in_data.cmd == CMD_POP_BACK || in_data.cmd == CMD_WALK_BWD) begin
              rd_ptr_next = ring_fwd(head, count - CNT_W'(1));
            end else begin
              rd_ptr_next = head;
            end
          end
        end
      endcase
    end else if (ctl.emit) begin
      // One entry of a run goes to the output register
      load            = 1'b1;
      res.out_value   = ITEM_W'(rdata);
      res.status      = ST_OK;
      res.last_of_run = (left == CNT_W'(1));
      left_next       = left - CNT_W'(1);
      case (run_cmd)
        CMD_POP_FRONT: begin
          head_next  = ring_fwd(head, CNT_W'(1));
          count_next = count - CNT_W'(1);
        end
        CMD_POP_BACK: begin
          count_next = count - CNT_W'(1);
        end
        CMD_DRAIN: begin
          head_next   = ring_fwd(head, CNT_W'(1));
          count_next  = count - CNT_W'(1);
          rd_ptr_next = ring_fwd(rd_ptr, CNT_W'(1));
        end
        CMD_WALK_FWD: begin
          rd_ptr_next = ring_fwd(rd_ptr, CNT_W'(1));
        end
        CMD_WALK_BWD: begin
          rd_ptr_next = ring_back(rd_ptr);
        end
        default: begin
          count_next = count;
        end
      endcase
      res_count = count_next;
    end

    res.entry_count = COUNT_OUT_W'(res_count);
    res.is_empty    = (res_count == '0);
  end

  // Entry storage with registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.item_value[STORE_W-1:0];
    end
    rdata <= mem[rd_ptr_next];
  end

  // Pointer, count and run registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      left      <= left_next;
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    run_cmd <= run_cmd_next;
    if (load) begin
      out_data <= res;
    end
  end

endmodule
